// ===== design/rpcf_pkg.sv =====
package rpcf_pkg;

    localparam int PIXEL_W = 32;
    localparam int CH_W    = 8;
    localparam int AMT_W   = 10;
    localparam int CFG_W   = 24;
    localparam int IDX_W   = 3;

    typedef enum logic [2:0] {
        MODE_GRAY    = 3'd0,
        MODE_DARKEN  = 3'd1,
        MODE_BRIGHT  = 3'd2,
        MODE_INVERT  = 3'd3,
        MODE_BALANCE = 3'd4
    } t_filter_mode;

    typedef enum logic [1:0] {
        FMT_RGB555   = 2'd0,
        FMT_RGB565   = 2'd1,
        FMT_RGB888   = 2'd2,
        FMT_ARGB8888 = 2'd3
    } t_pix_fmt;

    localparam logic [IDX_W-1:0] REG_FILTER_MODE  = 3'd0;
    localparam logic [IDX_W-1:0] REG_PIXEL_FORMAT = 3'd1;
    localparam logic [IDX_W-1:0] REG_RED_AMOUNT   = 3'd2;
    localparam logic [IDX_W-1:0] REG_GREEN_AMOUNT = 3'd3;
    localparam logic [IDX_W-1:0] REG_BLUE_AMOUNT  = 3'd4;
    localparam logic [IDX_W-1:0] REG_KEY_ENABLE   = 3'd5;
    localparam logic [IDX_W-1:0] REG_KEY_COLOR    = 3'd6;

    typedef struct packed {
        logic [2:0]              filter_mode;
        t_pix_fmt                pixel_format;
        logic signed [AMT_W-1:0] red_amount;
        logic signed [AMT_W-1:0] green_amount;
        logic signed [AMT_W-1:0] blue_amount;
        logic                    key_enable;
        logic [23:0]             key_color;
    } t_cfg;

    // A five-bit field widened to eight bits; a nonzero value gets its low bits filled.
    function automatic logic [CH_W-1:0] expand5(logic [4:0] v);
        return (v == 5'd0) ? 8'd0 : {v, 3'b111};
    endfunction

    function automatic logic [CH_W-1:0] expand6(logic [5:0] v);
        return (v == 6'd0) ? 8'd0 : {v[5:1], 3'b111};
    endfunction

    // Sums stay below 768, so multiplying by 683/2048 gives the exact floor.
    function automatic logic [CH_W-1:0] div3(logic [9:0] s);
        logic [20:0] p;
        p = {11'd0, s} * 21'd683;
        return p[18:11];
    endfunction

endpackage

// ===== design/rpcf_channel.sv =====
module rpcf_channel (
    input  logic [rpcf_pkg::CH_W-1:0]         i_c,
    input  logic signed [rpcf_pkg::AMT_W-1:0] i_amt,
    input  logic [2:0]                        i_mode,
    output logic [rpcf_pkg::CH_W-1:0]         o_c
);
    import rpcf_pkg::*;

    logic                    dark;
    logic [8:0]              amount;
    logic [8:0]              clamp_pos;
    logic [8:0]              clamp_neg;
    logic [AMT_W-1:0]        neg_amt;
    logic [CH_W-1:0]         mul_a;
    logic [8:0]              mul_b;
    logic [16:0]             prod;
    logic [CH_W-1:0]         scaled;
    logic [CH_W-1:0]         adjusted;

    assign neg_amt = AMT_W'(-i_amt);

    // Amount limited to 0..256 and, for a negative balance, its magnitude limited to 256.
    assign clamp_pos = (i_amt < 10'sd0) ? 9'd0 :
                       (i_amt > 10'sd256) ? 9'd256 : i_amt[8:0];
    assign clamp_neg = (i_amt < -10'sd256) ? 9'd256 : neg_amt[8:0];

    always_comb begin
        dark   = 1'b0;
        amount = clamp_pos;
        case (i_mode)
            MODE_DARKEN: begin
                dark = 1'b1;
            end
            MODE_BALANCE: begin
                if (i_amt < 10'sd0) begin
                    dark   = 1'b1;
                    amount = clamp_neg;
                end
            end
            default: begin
                dark = 1'b0;
            end
        endcase
    end

    // Darken scales c by 256-a; brighten scales the headroom 255-c by a.
    assign mul_a    = dark ? i_c : (8'd255 - i_c);
    assign mul_b    = dark ? (9'd256 - amount) : amount;
    assign prod     = {9'd0, mul_a} * {8'd0, mul_b};
    assign scaled   = prod[15:8];
    assign adjusted = dark ? scaled : (i_c + scaled);

    always_comb begin
        case (i_mode) inside
            MODE_DARKEN, MODE_BRIGHT, MODE_BALANCE: o_c = adjusted;
            MODE_INVERT:                            o_c = ~i_c;
            default:                                o_c = i_c;
        endcase
    end

endmodule

// ===== design/rpcf_core.sv =====
module rpcf_core (
    input  logic [rpcf_pkg::PIXEL_W-1:0] i_pixel,
    input  rpcf_pkg::t_cfg               i_cfg,
    output logic [rpcf_pkg::PIXEL_W-1:0] o_pixel,
    output logic                         o_keyed
);
    import rpcf_pkg::*;

    logic [CH_W-1:0]    r_ch;
    logic [CH_W-1:0]    g_ch;
    logic [CH_W-1:0]    b_ch;
    logic [CH_W-1:0]    alpha;
    logic [PIXEL_W-1:0] masked;
    logic [9:0]         sum;
    logic [CH_W-1:0]    gray;
    logic [CH_W-1:0]    r_flt;
    logic [CH_W-1:0]    g_flt;
    logic [CH_W-1:0]    b_flt;
    logic [CH_W-1:0]    r_fin;
    logic [CH_W-1:0]    g_fin;
    logic [CH_W-1:0]    b_fin;
    logic [PIXEL_W-1:0] packed_px;

    always_comb begin
        alpha = 8'd0;
        unique case (i_cfg.pixel_format)
            FMT_RGB555: begin
                masked = {16'd0, i_pixel[15:0]};
                r_ch   = expand5(i_pixel[14:10]);
                g_ch   = expand5(i_pixel[9:5]);
                b_ch   = expand5(i_pixel[4:0]);
            end
            FMT_RGB565: begin
                masked = {16'd0, i_pixel[15:0]};
                r_ch   = expand5(i_pixel[15:11]);
                g_ch   = expand6(i_pixel[10:5]);
                b_ch   = expand5(i_pixel[4:0]);
            end
            FMT_RGB888: begin
                masked = {8'd0, i_pixel[23:0]};
                r_ch   = i_pixel[7:0];
                g_ch   = i_pixel[15:8];
                b_ch   = i_pixel[23:16];
            end
            default: begin
                masked = i_pixel;
                alpha  = i_pixel[31:24];
                r_ch   = i_pixel[23:16];
                g_ch   = i_pixel[15:8];
                b_ch   = i_pixel[7:0];
            end
        endcase
    end

    assign o_keyed = i_cfg.key_enable && ({b_ch, g_ch, r_ch} == i_cfg.key_color);

    assign sum  = {2'd0, r_ch} + {2'd0, g_ch} + {2'd0, b_ch};
    assign gray = div3(sum);

    rpcf_channel u_red (
        .i_c    (r_ch),
        .i_amt  (i_cfg.red_amount),
        .i_mode (i_cfg.filter_mode),
        .o_c    (r_flt)
    );

    rpcf_channel u_green (
        .i_c    (g_ch),
        .i_amt  (i_cfg.green_amount),
        .i_mode (i_cfg.filter_mode),
        .o_c    (g_flt)
    );

    rpcf_channel u_blue (
        .i_c    (b_ch),
        .i_amt  (i_cfg.blue_amount),
        .i_mode (i_cfg.filter_mode),
        .o_c    (b_flt)
    );

    assign r_fin = (i_cfg.filter_mode == MODE_GRAY) ? gray : r_flt;
    assign g_fin = (i_cfg.filter_mode == MODE_GRAY) ? gray : g_flt;
    assign b_fin = (i_cfg.filter_mode == MODE_GRAY) ? gray : b_flt;

    always_comb begin
        unique case (i_cfg.pixel_format)
            FMT_RGB555: packed_px = {17'd0, r_fin[7:3], g_fin[7:3], b_fin[7:3]};
            FMT_RGB565: packed_px = {16'd0, r_fin[7:3], g_fin[7:2], b_fin[7:3]};
            FMT_RGB888: packed_px = {8'd0, b_fin, g_fin, r_fin};
            default:    packed_px = {alpha, r_fin, g_fin, b_fin};
        endcase
    end

    assign o_pixel = o_keyed ? masked : packed_px;

endmodule

// ===== design/rgb_pixel_color_filter_top.sv =====
// A word accepted into the input register passes through the filter logic into the
// result register, which holds it on the output until the consumer takes it.
// Throughput: one word per cycle while the consumer does not stall; the input register
// feeds the filter logic, and it refills whenever it is empty or the result stage advances.
// Reset (synchronous, active low) empties both stages and returns the configuration
// registers to grayscale, argb8888, zero amounts and keying off.
module rgb_pixel_color_filter_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [rpcf_pkg::PIXEL_W-1:0]       i_pixel_in,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [rpcf_pkg::PIXEL_W-1:0]       o_pixel_out,
    output logic                               o_was_keyed,
    input  logic                               i_cfg_we,
    input  logic [rpcf_pkg::IDX_W-1:0]         i_cfg_index,
    input  logic [rpcf_pkg::CFG_W-1:0]         i_cfg_data
);
    import rpcf_pkg::*;

    t_cfg               r_cfg;
    logic               r_in_valid;
    logic [PIXEL_W-1:0] r_in_pixel;
    logic               r_out_valid;
    logic [PIXEL_W-1:0] r_out_pixel;
    logic               r_out_keyed;
    logic               adv_out;
    logic               adv_in;
    logic [PIXEL_W-1:0] n_out_pixel;
    logic               n_out_keyed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.filter_mode  <= MODE_GRAY;
            r_cfg.pixel_format <= FMT_ARGB8888;
            r_cfg.red_amount   <= '0;
            r_cfg.green_amount <= '0;
            r_cfg.blue_amount  <= '0;
            r_cfg.key_enable   <= 1'b0;
            r_cfg.key_color    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FILTER_MODE:  r_cfg.filter_mode  <= i_cfg_data[2:0];
                REG_PIXEL_FORMAT: r_cfg.pixel_format <= t_pix_fmt'(i_cfg_data[1:0]);
                REG_RED_AMOUNT:   r_cfg.red_amount   <= i_cfg_data[AMT_W-1:0];
                REG_GREEN_AMOUNT: r_cfg.green_amount <= i_cfg_data[AMT_W-1:0];
                REG_BLUE_AMOUNT:  r_cfg.blue_amount  <= i_cfg_data[AMT_W-1:0];
                REG_KEY_ENABLE:   r_cfg.key_enable   <= i_cfg_data[0];
                REG_KEY_COLOR:    r_cfg.key_color    <= i_cfg_data[23:0];
                default: begin
                end
            endcase
        end
    end

    // The result register frees up whenever its word is taken, so the input stage
    // can refill in the same cycle.
    assign adv_out = !r_out_valid || !i_stall;
    assign adv_in  = !r_in_valid || adv_out;
    assign o_stall = !adv_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (adv_in) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_in && i_valid) begin
            r_in_pixel <= i_pixel_in;
        end
    end

    rpcf_core u_core (
        .i_pixel (r_in_pixel),
        .i_cfg   (r_cfg),
        .o_pixel (n_out_pixel),
        .o_keyed (n_out_keyed)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv_out) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_out && r_in_valid) begin
            r_out_pixel <= n_out_pixel;
            r_out_keyed <= n_out_keyed;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_pixel_out = r_out_pixel;
    assign o_was_keyed = r_out_keyed;

endmodule

// ===== design/rpcf_checker.sv =====
module rpcf_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic                               o_stall,
    input  logic                               o_valid,
    input  logic                               i_stall,
    input  logic [rpcf_pkg::PIXEL_W-1:0]       o_pixel_out,
    input  logic                               o_was_keyed
);
    import rpcf_pkg::*;

    // A word held back by the consumer stays on the output unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pixel_out) && $stable(o_was_keyed))
        else $error("output word changed while stalled");

    // The output stage is empty after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // Back-pressure upstream only when both stages are full and the consumer stalls.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a full pipeline");

    // An accepted word guarantees a result on the output once it has passed the input and result registers.
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> ##1 o_valid)
        else $error("accepted word did not reach the output");

endmodule

bind rgb_pixel_color_filter_top rpcf_checker u_rpcf_checker (.*);

// ===== bench/rgb_pixel_color_filter_top_tb.sv =====
module rgb_pixel_color_filter_top_tb;

    import rpcf_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES = 25;
    localparam int WORDS_PER_PHASE = 75;
    // Index past the register list, and a filter mode with no filter behind it.
    localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;
    localparam logic [2:0] MODE_SPARE = 3'd7;

    typedef struct packed {
        logic [7:0]  a;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [31:0] masked;
    } t_channels;

    typedef struct packed {
        logic [31:0] pixel;
        logic        keyed;
    } t_filtered_word;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [PIXEL_W-1:0]   i_pixel_in;
    logic                 o_valid;
    logic                 i_stall;
    logic [PIXEL_W-1:0]   o_pixel_out;
    logic                 o_was_keyed;
    logic                 i_cfg_we;
    logic [IDX_W-1:0]     i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    // Shadow copy of the configuration registers.
    logic [2:0]              cfg_mode;
    t_pix_fmt                cfg_fmt;
    logic signed [AMT_W-1:0] cfg_red;
    logic signed [AMT_W-1:0] cfg_green;
    logic signed [AMT_W-1:0] cfg_blue;
    logic                    cfg_key_on;
    logic [23:0]             cfg_key;

    t_filtered_word pending_words[$];
    int  mismatch_count;
    int  cycle_count;
    int  long_hold_cycles;
    bit  src_idle_on;
    bit  sink_idle_on;

    rgb_pixel_color_filter_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_pixel_in  (i_pixel_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_pixel_out (o_pixel_out),
        .o_was_keyed (o_was_keyed),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int clamp_amount(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic logic [7:0] darken(logic [7:0] c, int a);
        return 8'((int'(c) * (256 - a)) >> 8);
    endfunction

    function automatic logic [7:0] brighten(logic [7:0] c, int a);
        return 8'(int'(c) + ((a * (255 - int'(c))) >> 8));
    endfunction

    function automatic logic [7:0] widen5(logic [4:0] v);
        logic [7:0] c;
        c = {v, 3'b000};
        if (c != 8'd0) c = c | 8'h07;
        return c;
    endfunction

    function automatic logic [7:0] widen6(logic [5:0] v);
        logic [7:0] c;
        c = {v, 2'b00};
        if (c != 8'd0) c = c | 8'h07;
        return c;
    endfunction

    function automatic t_channels unpack_pixel(logic [31:0] pix);
        t_channels ch;
        ch.a = 8'd0;
        case (cfg_fmt)
            FMT_RGB555: begin
                ch.masked = {16'd0, pix[15:0]};
                ch.r = widen5(pix[14:10]);
                ch.g = widen5(pix[9:5]);
                ch.b = widen5(pix[4:0]);
            end
            FMT_RGB565: begin
                ch.masked = {16'd0, pix[15:0]};
                ch.r = widen5(pix[15:11]);
                ch.g = widen6(pix[10:5]);
                ch.b = widen5(pix[4:0]);
            end
            FMT_RGB888: begin
                ch.masked = {8'd0, pix[23:0]};
                ch.r = pix[7:0];
                ch.g = pix[15:8];
                ch.b = pix[23:16];
            end
            default: begin
                ch.masked = pix;
                ch.a = pix[31:24];
                ch.r = pix[23:16];
                ch.g = pix[15:8];
                ch.b = pix[7:0];
            end
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] shade(logic [7:0] c, logic signed [AMT_W-1:0] amt);
        int a;
        a = amt;
        case (cfg_mode)
            MODE_DARKEN:  return darken(c, clamp_amount(a, 0, 256));
            MODE_BRIGHT:  return brighten(c, clamp_amount(a, 0, 256));
            MODE_INVERT:  return 8'hFF - c;
            MODE_BALANCE: begin
                a = clamp_amount(a, -256, 256);
                return (a < 0) ? darken(c, -a) : brighten(c, a);
            end
            default:      return c;
        endcase
    endfunction

    function automatic t_filtered_word filter_pixel(logic [31:0] pix);
        t_filtered_word res;
        t_channels ch;
        int sum;
        ch = unpack_pixel(pix);
        if (cfg_key_on && ({ch.b, ch.g, ch.r} == cfg_key)) begin
            res.pixel = ch.masked;
            res.keyed = 1'b1;
            return res;
        end
        if (cfg_mode == MODE_GRAY) begin
            sum = int'(ch.r) + int'(ch.g) + int'(ch.b);
            ch.r = 8'(sum / 3);
            ch.g = ch.r;
            ch.b = ch.r;
        end else begin
            ch.r = shade(ch.r, cfg_red);
            ch.g = shade(ch.g, cfg_green);
            ch.b = shade(ch.b, cfg_blue);
        end
        case (cfg_fmt)
            FMT_RGB555: res.pixel = {17'd0, ch.r[7:3], ch.g[7:3], ch.b[7:3]};
            FMT_RGB565: res.pixel = {16'd0, ch.r[7:3], ch.g[7:2], ch.b[7:3]};
            FMT_RGB888: res.pixel = {8'd0, ch.b, ch.g, ch.r};
            default:    res.pixel = {ch.a, ch.r, ch.g, ch.b};
        endcase
        res.keyed = 1'b0;
        return res;
    endfunction

    function automatic int draw_wait(bit enabled);
        if (!enabled || $urandom_range(0, 1) == 0) return 0;
        return $urandom_range(1, 18);
    endfunction

    // Register value with random junk above the bits the register keeps.
    function automatic logic [CFG_W-1:0] with_junk(int val, int bits);
        logic [CFG_W-1:0] mask;
        mask = (24'd1 << bits) - 24'd1;
        return (24'($urandom) & ~mask) | (24'(val) & mask);
    endfunction

    function automatic int pick_amount();
        case ($urandom_range(0, 7))
            0:       return -256;
            1:       return 256;
            2:       return 0;
            3:       return int'($urandom_range(0, 1023)) - 512;
            default: return int'($urandom_range(0, 512)) - 256;
        endcase
    endfunction

    function automatic logic [31:0] random_pixel();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            REG_FILTER_MODE:  cfg_mode   = data[2:0];
            REG_PIXEL_FORMAT: cfg_fmt    = t_pix_fmt'(data[1:0]);
            REG_RED_AMOUNT:   cfg_red    = data[AMT_W-1:0];
            REG_GREEN_AMOUNT: cfg_green  = data[AMT_W-1:0];
            REG_BLUE_AMOUNT:  cfg_blue   = data[AMT_W-1:0];
            REG_KEY_ENABLE:   cfg_key_on = data[0];
            REG_KEY_COLOR:    cfg_key    = data[23:0];
            default: ;
        endcase
    endtask

    // Entered just after a rising edge; returns at the edge that accepts the word.
    task automatic send_pixel(input logic [31:0] pix);
        int gap;
        gap = draw_wait(src_idle_on);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_pixel_in <= pix;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        pending_words.push_back(filter_pixel(pix));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic test_reset_defaults();
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h80FF_0001);
        wait_drained();
    endtask

    task automatic test_filter_modes();
        write_reg(REG_FILTER_MODE, 24'(MODE_DARKEN));
        write_reg(REG_RED_AMOUNT, with_junk(256, AMT_W));
        write_reg(REG_GREEN_AMOUNT, with_junk(0, AMT_W));
        write_reg(REG_BLUE_AMOUNT, with_junk(128, AMT_W));
        send_pixel(32'h80FF_7F01);
        send_pixel(32'h01FF_FFFF);
        wait_drained();

        // Amounts outside the legal span are clamped.
        write_reg(REG_FILTER_MODE, 24'(MODE_BRIGHT));
        write_reg(REG_RED_AMOUNT, with_junk(511, AMT_W));
        write_reg(REG_GREEN_AMOUNT, with_junk(-512, AMT_W));
        write_reg(REG_BLUE_AMOUNT, with_junk(1, AMT_W));
        send_pixel(32'h7F00_807F);
        wait_drained();

        write_reg(REG_FILTER_MODE, 24'(MODE_INVERT));
        write_reg(REG_PIXEL_FORMAT, 24'(FMT_RGB888));
        send_pixel(32'h00A5_5A3C);
        send_pixel(32'hFFFF_FFFF);
        wait_drained();

        write_reg(REG_FILTER_MODE, 24'(MODE_BALANCE));
        write_reg(REG_PIXEL_FORMAT, 24'(FMT_RGB565));
        write_reg(REG_RED_AMOUNT, with_junk(-256, AMT_W));
        write_reg(REG_GREEN_AMOUNT, with_junk(-300, AMT_W));
        write_reg(REG_BLUE_AMOUNT, with_junk(256, AMT_W));
        send_pixel(32'h0000_FFFF);
        send_pixel(32'hFFFF_0821);
        wait_drained();

        write_reg(REG_FILTER_MODE, 24'(MODE_SPARE));
        write_reg(REG_PIXEL_FORMAT, 24'(FMT_RGB555));
        send_pixel(32'hFFFF_8000);
        send_pixel(32'h0000_7FFF);
        wait_drained();

        write_reg(REG_FILTER_MODE, 24'(MODE_GRAY));
        send_pixel(32'h0000_7C1F);
        wait_drained();
    endtask

    task automatic test_colour_key();
        t_channels kc;
        write_reg(REG_FILTER_MODE, 24'(MODE_INVERT));
        write_reg(REG_PIXEL_FORMAT, 24'(FMT_RGB555));
        kc = unpack_pixel(32'h0000_1234);
        write_reg(REG_KEY_COLOR, {kc.b, kc.g, kc.r});
        write_reg(REG_KEY_ENABLE, 24'd1);
        // Bit 15 is outside the 555 channels, so this still matches.
        send_pixel(32'h5A5A_9234);
        send_pixel(32'h0000_1235);
        wait_drained();

        write_reg(REG_PIXEL_FORMAT, 24'(FMT_ARGB8888));
        kc = unpack_pixel(32'h00C0_FFEE);
        write_reg(REG_KEY_COLOR, {kc.b, kc.g, kc.r});
        send_pixel(32'h55C0_FFEE);
        send_pixel(32'h55C0_FFEF);
        wait_drained();

        write_reg(REG_KEY_ENABLE, 24'd0);
        write_reg(REG_SPARE, 24'hFF_FFFF);
        send_pixel(32'h55C0_FFEE);
        wait_drained();
    endtask

    task automatic test_backpressure();
        int i;
        src_idle_on = 1'b0;
        long_hold_cycles = 150;
        for (i = 0; i < 30; i++) send_pixel(random_pixel());
        // The sender now waits for every word to come back before going on.
        wait_drained();
        src_idle_on = 1'b1;
        for (i = 0; i < 20; i++) send_pixel(random_pixel());
        wait_drained();
    endtask

    task automatic test_random_stream();
        int ph;
        int i;
        int mode;
        int sel;
        logic [31:0] key_pixel;
        logic [31:0] keep;
        t_channels kc;
        for (ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            sel = $urandom_range(0, 11);
            mode = (ph < 8) ? ph : ((sel < 10) ? (sel % 5) : $urandom_range(5, 7));
            write_reg(REG_FILTER_MODE, with_junk(mode, 3));
            write_reg(REG_PIXEL_FORMAT, with_junk($urandom_range(0, 3), 2));
            write_reg(REG_RED_AMOUNT, with_junk(pick_amount(), AMT_W));
            write_reg(REG_GREEN_AMOUNT, with_junk(pick_amount(), AMT_W));
            write_reg(REG_BLUE_AMOUNT, with_junk(pick_amount(), AMT_W));
            key_pixel = $urandom;
            kc = unpack_pixel(key_pixel);
            if ($urandom_range(0, 4) == 0)
                write_reg(REG_KEY_COLOR, 24'($urandom));
            else
                write_reg(REG_KEY_COLOR, {kc.b, kc.g, kc.r});
            write_reg(REG_KEY_ENABLE, with_junk($urandom_range(0, 1), 1));
            case (cfg_fmt)
                FMT_RGB555: keep = 32'h0000_7FFF;
                FMT_RGB565: keep = 32'h0000_FFFF;
                default:    keep = 32'h00FF_FFFF;
            endcase
            src_idle_on  = ($urandom_range(0, 3) != 0);
            sink_idle_on = ($urandom_range(0, 3) != 0);
            for (i = 0; i < WORDS_PER_PHASE; i++) begin
                if (cfg_key_on && $urandom_range(0, 3) == 0)
                    send_pixel((key_pixel & keep) | ($urandom & ~keep));
                else
                    send_pixel(random_pixel());
            end
        end
        wait_drained();
    endtask

    initial begin : word_sink
        int hold_wait;
        t_filtered_word want;
        hold_wait = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_valid === 1'b1 && i_stall === 1'b0) begin
                if (pending_words.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: word with nothing expected: pixel_out %h was_keyed %b",
                             $time, o_pixel_out, o_was_keyed);
                end else begin
                    want = pending_words.pop_front();
                    if (o_pixel_out !== want.pixel) begin
                        mismatch_count++;
                        $display("%0t: pixel_out expected %h actual %h",
                                 $time, want.pixel, o_pixel_out);
                    end
                    if (o_was_keyed !== want.keyed) begin
                        mismatch_count++;
                        $display("%0t: was_keyed expected %b actual %b",
                                 $time, want.keyed, o_was_keyed);
                    end
                end
                hold_wait = draw_wait(sink_idle_on);
            end else if (hold_wait > 0) begin
                hold_wait--;
            end
            if (long_hold_cycles > 0) begin
                long_hold_cycles--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= (hold_wait > 0);
            end
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count <= CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        mismatch_count   = 0;
        long_hold_cycles = 0;
        src_idle_on      = 1'b1;
        sink_idle_on     = 1'b1;
        cfg_mode   = MODE_GRAY;
        cfg_fmt    = FMT_ARGB8888;
        cfg_red    = '0;
        cfg_green  = '0;
        cfg_blue   = '0;
        cfg_key_on = 1'b0;
        cfg_key    = 24'd0;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_pixel_in  <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_filter_modes();
        test_colour_key();
        test_backpressure();
        test_random_stream();

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
